### rtl/core/lant_pkg.sv
// Shared types, codes and helpers for the Langton's ant step unit.
package lant_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int DEPTH     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_LIM   = (GRID_ROWS < 64) ? GRID_ROWS : 64;
    localparam int COL_LIM   = (GRID_COLS < 64) ? GRID_COLS : 64;

    localparam logic [1:0] CMD_STEP    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] HEAD_N = 2'd0;
    localparam logic [1:0] HEAD_E = 2'd1;
    localparam logic [1:0] HEAD_S = 2'd2;
    localparam logic [1:0] HEAD_W = 2'd3;

    localparam logic [2:0] REG_ROWS      = 3'd0;
    localparam logic [2:0] REG_COLS      = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;

    typedef logic [1:0] t_addr_sel;
    localparam t_addr_sel SEL_POS   = 2'd0;
    localparam t_addr_sel SEL_QUERY = 2'd1;
    localparam t_addr_sel SEL_CLEAR = 2'd2;

    typedef struct packed {
        logic      capture;
        logic      restart;
        logic      mem_rd;
        logic      clear_wr;
        logic      step_wr;
        logic      reply;
        t_addr_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic limit_hit;
        logic clear_last;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] row,
                                                    input logic [5:0] col);
        logic [31:0] a;
        a = 32'(row) * 32'(GRID_COLS) + 32'(col);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [5:0] row, input logic [5:0] col);
        return (32'(row) < 32'(GRID_ROWS)) && (32'(col) < 32'(GRID_COLS));
    endfunction

    // Zero acts as one; saturate to the grid and to 64.
    function automatic logic [6:0] board_size(input logic [6:0] cfg, input logic [6:0] lim);
        logic [6:0] n;
        n = (cfg == 7'd0) ? 7'd1 : cfg;
        if (n > lim) begin
            n = lim;
        end
        return n;
    endfunction

endpackage

### rtl/core/lant_ctrl.sv
// Sequencer for step, restart, read and the grid clearing pass.
module lant_ctrl import lant_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_STEP_RD = 3'd2;
    localparam logic [2:0] ST_STEP_WR = 3'd3;
    localparam logic [2:0] ST_POS_RD  = 3'd4;
    localparam logic [2:0] ST_Q_RD    = 3'd5;
    localparam logic [2:0] ST_CLEAR   = 3'd6;
    localparam logic [2:0] ST_REPLY   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_strobe;
    logic       w_accept;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_strobe;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_POS;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.sel      = SEL_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.capture = w_accept;
                o_cmd.restart = w_accept && (i_command == CMD_RESTART);
                if (w_accept) begin
                    unique case (i_command)
                        CMD_STEP:    n_state = i_stat.limit_hit ? ST_POS_RD : ST_STEP_RD;
                        CMD_RESTART: n_state = ST_CLEAR;
                        CMD_READ:    n_state = ST_Q_RD;
                        default:     n_state = ST_POS_RD;
                    endcase
                end
            end
            ST_STEP_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_STEP_WR;
            end
            ST_STEP_WR: begin
                o_cmd.step_wr = 1'b1;
                n_state       = ST_POS_RD;
            end
            ST_POS_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_REPLY;
            end
            ST_Q_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.sel    = SEL_QUERY;
                n_state      = ST_REPLY;
            end
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.sel      = SEL_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = ST_POS_RD;
                end
            end
            default: begin
                o_cmd.reply = 1'b1;
                n_state     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_REPLY);
        end
    end

`ifndef SYNTHESIS
    a_strobe_after_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) == ST_REPLY)
        else $error("result beat without reply state");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("not busy after accepted command");
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_WR) |-> $past(r_state) == ST_STEP_RD)
        else $error("cell write without preceding cell read");
    a_reply_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLY) |-> ($past(r_state) == ST_POS_RD || $past(r_state) == ST_Q_RD))
        else $error("reply without preceding memory read");
`endif

endmodule

### rtl/core/lant_dp.sv
// Grid memory, ant state, configuration registers and result registers.
module lant_dp import lant_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_query_row,
    input  logic [5:0]  i_query_col,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    output t_dp_stat    o_stat,
    output logic [5:0]  o_ant_row,
    output logic [5:0]  o_ant_col,
    output logic [1:0]  o_heading,
    output logic        o_cell_black,
    output logic        o_ant_here,
    output logic        o_wrapped,
    output logic [19:0] o_steps_taken,
    output logic        o_done_res
);

    logic [6:0]  r_rows, r_cols;
    logic [5:0]  r_start_row, r_start_col;
    logic [19:0] r_limit;

    logic [5:0]  r_pos_row, r_pos_col;
    logic [1:0]  r_face;
    logic [19:0] r_count;
    logic        r_wrap;
    logic [1:0]  r_cmd_code;
    logic [5:0]  r_qrow, r_qcol;

    logic        r_grid [DEPTH];
    logic        r_rd_data, r_rd_ok;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [6:0]  w_nrows, w_ncols;
    logic [ADDR_W-1:0] w_addr;
    logic        w_addr_ok, w_we, w_wdata, w_col;
    logic [1:0]  w_face;
    logic [6:0]  w_mr, w_mc;
    logic        w_off, w_wrap_now;

    assign w_nrows = board_size(r_rows, 7'(ROW_LIM));
    assign w_ncols = board_size(r_cols, 7'(COL_LIM));

    assign o_stat.limit_hit  = (r_count >= r_limit);
    assign o_stat.clear_last = (r_clr_addr == ADDR_W'(DEPTH - 1));

    always_comb begin
        unique case (i_cmd.sel)
            SEL_POS: begin
                w_addr    = cell_addr(r_pos_row, r_pos_col);
                w_addr_ok = in_grid(r_pos_row, r_pos_col);
            end
            SEL_QUERY: begin
                w_addr    = cell_addr(r_qrow, r_qcol);
                w_addr_ok = in_grid(r_qrow, r_qcol);
            end
            default: begin
                w_addr    = r_clr_addr;
                w_addr_ok = 1'b1;
            end
        endcase
    end

    // Turn on the color read, then move one cell.
    assign w_col  = r_rd_data & r_rd_ok;
    assign w_face = w_col ? (r_face - 2'd1) : (r_face + 2'd1);

    always_comb begin
        w_mr  = {1'b0, r_pos_row};
        w_mc  = {1'b0, r_pos_col};
        w_off = 1'b0;
        unique case (w_face)
            HEAD_N: begin
                if (r_pos_row == 6'd0) begin
                    w_off = 1'b1;
                end else begin
                    w_mr = w_mr - 7'd1;
                end
            end
            HEAD_E: w_mc = w_mc + 7'd1;
            HEAD_S: w_mr = w_mr + 7'd1;
            default: begin
                if (r_pos_col == 6'd0) begin
                    w_off = 1'b1;
                end else begin
                    w_mc = w_mc - 7'd1;
                end
            end
        endcase
        w_wrap_now = w_off || (w_mr >= w_nrows) || (w_mc >= w_ncols);
    end

    assign w_we    = i_cmd.clear_wr || (i_cmd.step_wr && w_addr_ok);
    assign w_wdata = i_cmd.clear_wr ? 1'b0 : ~w_col;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_grid[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_grid[w_addr];
            r_rd_ok   <= w_addr_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 7'd64;
            r_cols      <= 7'd64;
            r_start_row <= '0;
            r_start_col <= '0;
            r_limit     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:      r_rows      <= i_cfg_data[6:0];
                REG_COLS:      r_cols      <= i_cfg_data[6:0];
                REG_START_ROW: r_start_row <= i_cfg_data[5:0];
                REG_START_COL: r_start_col <= i_cfg_data[5:0];
                REG_LIMIT:     r_limit     <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_row  <= '0;
            r_pos_col  <= '0;
            r_face     <= HEAD_N;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= o_stat.clear_last ? '0 : r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.restart) begin
                if ({1'b0, r_start_row} < w_nrows && {1'b0, r_start_col} < w_ncols) begin
                    r_pos_row <= r_start_row;
                    r_pos_col <= r_start_col;
                end else begin
                    r_pos_row <= '0;
                    r_pos_col <= '0;
                end
                r_face  <= HEAD_N;
                r_count <= '0;
            end else if (i_cmd.step_wr) begin
                r_face    <= w_face;
                r_pos_row <= w_wrap_now ? 6'd0 : w_mr[5:0];
                r_pos_col <= w_wrap_now ? 6'd0 : w_mc[5:0];
                r_count   <= r_count + 20'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_code <= i_command;
            r_qrow     <= i_query_row;
            r_qcol     <= i_query_col;
            r_wrap     <= 1'b0;
        end else if (i_cmd.step_wr) begin
            r_wrap <= w_wrap_now;
        end
        if (i_cmd.reply) begin
            o_ant_row     <= r_pos_row;
            o_ant_col     <= r_pos_col;
            o_heading     <= r_face;
            o_cell_black  <= r_rd_data & r_rd_ok;
            o_ant_here    <= (r_cmd_code == CMD_READ) && (r_qrow == r_pos_row)
                             && (r_qcol == r_pos_col);
            o_wrapped     <= r_wrap;
            o_steps_taken <= r_count;
            o_done_res    <= (r_count >= r_limit);
        end
    end

endmodule

### rtl/core/langtons_ant_step_unit.sv
// Langton's ant step unit: a command is taken when i_start is high and o_busy
// is low. A step runs from acceptance to the result beat through a read of
// the old cell, its write, a read of the new cell and the reply; an ignored
// step or a cell read does one read and the reply, and a restart first walks
// the whole single-port grid memory one cell per cycle to clear it. After
// reset the same clearing pass runs with o_busy high and gives no result.
// Each result appears for one cycle with o_valid high and cannot be held off;
// the next command may be accepted in that same cycle. Configuration writes
// are taken at any edge with i_cfg_we high.
module langtons_ant_step_unit import lant_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_query_row,
    input  logic [5:0]  i_query_col,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    output logic        o_valid,
    output logic [5:0]  o_ant_row,
    output logic [5:0]  o_ant_col,
    output logic [1:0]  o_heading,
    output logic        o_cell_black,
    output logic        o_ant_here,
    output logic        o_wrapped,
    output logic [19:0] o_steps_taken,
    output logic        o_done_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lant_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (o_busy),
        .o_valid   (o_valid)
    );

    lant_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_command     (i_command),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_stat        (w_stat),
        .o_ant_row     (o_ant_row),
        .o_ant_col     (o_ant_col),
        .o_heading     (o_heading),
        .o_cell_black  (o_cell_black),
        .o_ant_here    (o_ant_here),
        .o_wrapped     (o_wrapped),
        .o_steps_taken (o_steps_taken),
        .o_done_res    (o_done_res)
    );

endmodule

### bench/langtons_ant_step_unit_tb.sv
// Self-checking bench for the Langton's ant step unit: command beats against an in-bench ant.
`timescale 1ns / 100ps

module langtons_ant_step_unit_tb;
    import lant_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 30_000_000;
    localparam int PLAN_LEN    = 33;
    localparam int PER_PHASE   = 225;

    typedef struct packed {
        logic [5:0]  ant_row;
        logic [5:0]  ant_col;
        logic [1:0]  heading;
        logic        cell_black;
        logic        ant_here;
        logic        wrapped;
        logic [19:0] steps_taken;
        logic        done_res;
    } ant_result_t;

    localparam ant_result_t NO_RESULT = '0;

    typedef enum logic [1:0] {ROW_CMD, ROW_CFG, ROW_FIXED} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  reg_idx;
        logic [19:0] reg_val;
        logic [1:0]  cmd;
        logic [5:0]  qr;
        logic [5:0]  qc;
        ant_result_t want;
    } plan_row_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_command = CMD_STEP;
    logic [5:0]  i_query_row = '0;
    logic [5:0]  i_query_col = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = REG_ROWS;
    logic [19:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_valid;
    logic [5:0]  o_ant_row;
    logic [5:0]  o_ant_col;
    logic [1:0]  o_heading;
    logic        o_cell_black;
    logic        o_ant_here;
    logic        o_wrapped;
    logic [19:0] o_steps_taken;
    logic        o_done_res;

    langtons_ant_step_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_command     (i_command),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_ant_row     (o_ant_row),
        .o_ant_col     (o_ant_col),
        .o_heading     (o_heading),
        .o_cell_black  (o_cell_black),
        .o_ant_here    (o_ant_here),
        .o_wrapped     (o_wrapped),
        .o_steps_taken (o_steps_taken),
        .o_done_res    (o_done_res)
    );

    // In-bench copy of the ant, its grid and its registers.
    bit          grid_black [DEPTH];
    logic [5:0]  ant_r = '0;
    logic [5:0]  ant_c = '0;
    logic [1:0]  ant_dir = HEAD_N;
    logic [19:0] ant_steps = '0;
    logic [6:0]  cfg_rows = 7'd64;
    logic [6:0]  cfg_cols = 7'd64;
    logic [5:0]  cfg_srow = '0;
    logic [5:0]  cfg_scol = '0;
    logic [19:0] cfg_limit = '0;

    ant_result_t ant_expected_q [$];
    int          n_fail = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;

    plan_row_t opening_plan [PLAN_LEN] = '{
        // power-up state: step limit is zero, so the step is ignored
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0,
          '{6'd0, 6'd0, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b1}},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_READ, 6'd63, 6'd63,
          '{6'd0, 6'd0, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b1}},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_READ, 6'd0, 6'd0,
          '{6'd0, 6'd0, HEAD_N, 1'b0, 1'b1, 1'b0, 20'd0, 1'b1}},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_UNUSED, 6'd63, 6'd63,
          '{6'd0, 6'd0, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b1}},
        '{ROW_CFG, REG_LIMIT, 20'hFFFFF, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_START_ROW, 20'd63, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_START_COL, 20'd63, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_RESTART, 6'd0, 6'd0,
          '{6'd63, 6'd63, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b0}},
        // east off the last column: back to the corner
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0,
          '{6'd0, 6'd0, HEAD_E, 1'b0, 1'b0, 1'b1, 20'd1, 1'b0}},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_READ, 6'd63, 6'd63, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_READ, 6'd1, 6'd0, NO_RESULT},
        // zero rows act as one, oversize columns saturate; ant now off the board
        '{ROW_CFG, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_COLS, 20'hFFFFF, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_SPARE_LO, 20'hABCDE, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        // start cell outside the board: restart lands in the corner
        '{ROW_CFG, REG_ROWS, 20'd64, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_COLS, 20'd8, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_START_ROW, 20'd5, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_START_COL, 20'd20, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_RESTART, 6'd0, 6'd0,
          '{6'd0, 6'd0, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{ROW_CFG, REG_START_COL, 20'd3, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CFG, REG_LIMIT, 20'd3, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_RESTART, 6'd0, 6'd0,
          '{6'd5, 6'd3, HEAD_N, 1'b0, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0, NO_RESULT},
        // fourth step hits the limit of three
        '{ROW_FIXED, REG_ROWS, 20'd0, CMD_STEP, 6'd0, 6'd0,
          '{6'd6, 6'd3, HEAD_W, 1'b0, 1'b0, 1'b0, 20'd3, 1'b1}},
        '{ROW_CMD, REG_ROWS, 20'd0, CMD_READ, 6'd5, 6'd3, NO_RESULT}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the in-bench ant and return the beat it should produce.
    function automatic ant_result_t advance_ant(input logic [1:0] cmd,
                                                input logic [5:0] qr,
                                                input logic [5:0] qc);
        ant_result_t res;
        logic [6:0]  nrows;
        logic [6:0]  ncols;
        logic [6:0]  nr;
        logic [6:0]  nc;
        logic        old_black;
        logic        off;
        res   = '0;
        nrows = (cfg_rows == 7'd0) ? 7'd1 : ((cfg_rows > 7'd64) ? 7'd64 : cfg_rows);
        ncols = (cfg_cols == 7'd0) ? 7'd1 : ((cfg_cols > 7'd64) ? 7'd64 : cfg_cols);
        case (cmd)
            CMD_STEP: begin
                if (ant_steps < cfg_limit) begin
                    old_black = grid_black[{ant_r, ant_c}];
                    grid_black[{ant_r, ant_c}] = ~old_black;
                    ant_dir = old_black ? ant_dir - 2'd1 : ant_dir + 2'd1;
                    nr  = {1'b0, ant_r};
                    nc  = {1'b0, ant_c};
                    off = 1'b0;
                    case (ant_dir)
                        HEAD_N: begin
                            if (nr == 7'd0) off = 1'b1;
                            else nr = nr - 7'd1;
                        end
                        HEAD_E: nc = nc + 7'd1;
                        HEAD_S: nr = nr + 7'd1;
                        default: begin
                            if (nc == 7'd0) off = 1'b1;
                            else nc = nc - 7'd1;
                        end
                    endcase
                    // off the board in use: jump to the corner, keep heading
                    if (off || nr >= nrows || nc >= ncols) begin
                        nr = '0;
                        nc = '0;
                        res.wrapped = 1'b1;
                    end
                    ant_r = nr[5:0];
                    ant_c = nc[5:0];
                    ant_steps = ant_steps + 20'd1;
                end
                res.cell_black = grid_black[{ant_r, ant_c}];
            end
            CMD_RESTART: begin
                foreach (grid_black[i]) grid_black[i] = 1'b0;
                if ({1'b0, cfg_srow} < nrows && {1'b0, cfg_scol} < ncols) begin
                    ant_r = cfg_srow;
                    ant_c = cfg_scol;
                end else begin
                    ant_r = '0;
                    ant_c = '0;
                end
                ant_dir   = HEAD_N;
                ant_steps = '0;
                res.cell_black = grid_black[{ant_r, ant_c}];
            end
            CMD_READ: begin
                res.cell_black = grid_black[{qr, qc}];
                res.ant_here   = (qr == ant_r) && (qc == ant_c);
            end
            default: res.cell_black = grid_black[{ant_r, ant_c}];
        endcase
        res.ant_row     = ant_r;
        res.ant_col     = ant_c;
        res.heading     = ant_dir;
        res.steps_taken = ant_steps;
        res.done_res    = (ant_steps >= cfg_limit);
        return res;
    endfunction

    // Present one command beat, hold it until taken, record what it should return.
    task automatic issue_cmd(input logic [1:0] cmd, input logic [5:0] qr,
                             input logic [5:0] qc, input bit fixed,
                             input ant_result_t want);
        int          gap;
        ant_result_t got;
        gap = 0;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_command   <= cmd;
        i_query_row <= qr;
        i_query_col <= qc;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        got = advance_ant(cmd, qr, qc);
        ant_expected_q.push_back(fixed ? want : got);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_ROWS:      cfg_rows  = val[6:0];
            REG_COLS:      cfg_cols  = val[6:0];
            REG_START_ROW: cfg_srow  = val[5:0];
            REG_START_COL: cfg_scol  = val[5:0];
            REG_LIMIT:     cfg_limit = val;
            default: ;
        endcase
    endtask

    // Drop start and wait until every beat is back and the block is free.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (ant_expected_q.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("langtons_ant_step_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        ant_result_t exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (ant_expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_fail++;
            end else begin
                exp_r = ant_expected_q.pop_front();
                if (o_ant_row !== exp_r.ant_row) begin
                    $error("ant_row: expected %0d, got %0d", exp_r.ant_row, o_ant_row);
                    n_fail++;
                end
                if (o_ant_col !== exp_r.ant_col) begin
                    $error("ant_col: expected %0d, got %0d", exp_r.ant_col, o_ant_col);
                    n_fail++;
                end
                if (o_heading !== exp_r.heading) begin
                    $error("heading: expected %0d, got %0d", exp_r.heading, o_heading);
                    n_fail++;
                end
                if (o_cell_black !== exp_r.cell_black) begin
                    $error("cell_black: expected %0d, got %0d", exp_r.cell_black,
                           o_cell_black);
                    n_fail++;
                end
                if (o_ant_here !== exp_r.ant_here) begin
                    $error("ant_here: expected %0d, got %0d", exp_r.ant_here, o_ant_here);
                    n_fail++;
                end
                if (o_wrapped !== exp_r.wrapped) begin
                    $error("wrapped: expected %0d, got %0d", exp_r.wrapped, o_wrapped);
                    n_fail++;
                end
                if (o_steps_taken !== exp_r.steps_taken) begin
                    $error("steps_taken: expected %0d, got %0d", exp_r.steps_taken,
                           o_steps_taken);
                    n_fail++;
                end
                if (o_done_res !== exp_r.done_res) begin
                    $error("done_res: expected %0d, got %0d", exp_r.done_res, o_done_res);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        bit          prev_cfg;
        int          counted;
        int          seq_left;
        int          pick;
        logic [1:0]  cmd;
        logic [5:0]  qr;
        logic [5:0]  qc;
        logic [6:0]  new_rows;
        logic [6:0]  new_cols;
        logic [5:0]  new_srow;
        logic [5:0]  new_scol;
        logic [19:0] new_limit;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the power-up clearing pass is over
        wait_idle();

        prev_cfg = 1'b0;
        foreach (opening_plan[k]) begin
            if (opening_plan[k].kind == ROW_CFG) begin
                if (!prev_cfg) wait_idle();
                write_reg(opening_plan[k].reg_idx, opening_plan[k].reg_val);
                prev_cfg = 1'b1;
            end else begin
                issue_cmd(opening_plan[k].cmd, opening_plan[k].qr, opening_plan[k].qc,
                          opening_plan[k].kind == ROW_FIXED, opening_plan[k].want);
                prev_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    new_rows = 7'd64; new_cols = 7'd64;
                    new_srow = 6'd32; new_scol = 6'd32; new_limit = 20'hFFFFF;
                    idle_pct = 0;
                end
                1: begin
                    new_rows = 7'd4; new_cols = 7'd6;
                    new_srow = 6'd1; new_scol = 6'd2; new_limit = 20'd40;
                    idle_pct = 75;
                end
                3: begin
                    new_rows = 7'd1; new_cols = 7'd1;
                    new_srow = 6'd0; new_scol = 6'd0;
                    new_limit = 20'($urandom_range(20'hFFFFF));
                    idle_pct = 0;
                end
                4: begin
                    new_rows = 7'd64; new_cols = 7'd2;
                    new_srow = 6'd63; new_scol = 6'd1; new_limit = 20'd60;
                    idle_pct = 75;
                end
                default: begin
                    new_rows  = 7'($urandom_range(127));
                    new_cols  = 7'($urandom_range(127));
                    new_srow  = 6'($urandom_range(63));
                    new_scol  = 6'($urandom_range(63));
                    new_limit = 20'($urandom_range(10, 300));
                    idle_pct  = 13;
                    write_reg(REG_SPARE_HI, 20'($urandom));
                end
            endcase
            write_reg(REG_ROWS, 20'(new_rows));
            write_reg(REG_COLS, 20'(new_cols));
            write_reg(REG_START_ROW, 20'(new_srow));
            write_reg(REG_START_COL, 20'(new_scol));
            write_reg(REG_LIMIT, new_limit);

            // a few beats first carry on with the old ant under the new board
            counted  = 0;
            seq_left = $urandom_range(5);
            while (counted < PER_PHASE) begin
                pick = $urandom_range(99);
                if (seq_left == 0) begin
                    cmd = CMD_RESTART;
                    seq_left = $urandom_range(30, 80);
                end else begin
                    seq_left--;
                    if (pick < 68) cmd = CMD_STEP;
                    else if (pick < 93) cmd = CMD_READ;
                    else if (pick < 98) cmd = CMD_UNUSED;
                    else cmd = CMD_RESTART;
                end
                case ($urandom_range(2))
                    0: begin
                        qr = ant_r;
                        qc = ant_c;
                    end
                    1: begin
                        qr = 6'($urandom_range(7));
                        qc = 6'($urandom_range(7));
                    end
                    default: begin
                        qr = 6'($urandom_range(63));
                        qc = 6'($urandom_range(63));
                    end
                endcase
                issue_cmd(cmd, qr, qc, 1'b0, NO_RESULT);
                counted++;
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("langtons_ant_step_unit_tb: PASS");
        end else begin
            $display("langtons_ant_step_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
